// ===== design/qlse_pkg.sv =====
package qlse_pkg;

    // pixel word is {red, green, blue}
    localparam int PIX_W = 24;

    // 3-bit line codes for one data bit
    localparam logic [2:0] CODE_ONE  = 3'b110;
    localparam logic [2:0] CODE_ZERO = 3'b100;

    // encoded bytes per led and per color
    localparam int SLOTS           = 9;
    localparam int SLOTS_PER_COLOR = 3;
    localparam logic [3:0] SLOT_LAST = 4'(SLOTS - 1);

    // command codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    // lanes 0..3 carry panels 2, 0, 1, 3
    localparam logic [1:0] LANE_PANEL [4] = '{2'd2, 2'd0, 2'd1, 2'd3};

    typedef struct packed {
        logic       op;
        logic [6:0] col;
        logic [4:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] lane_word;
        logic [3:0]  byte_slot;
        logic [8:0]  led_number;
        logic        group_last;
        logic        frame_last;
    } word_item_t;

    // each data bit becomes a 3-bit code, msb of the byte at the top
    function automatic logic [23:0] encode_byte(input logic [7:0] v);
        logic [23:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[3*i +: 3] = v[i] ? CODE_ONE : CODE_ZERO;
        end
        return r;
    endfunction

    // one encoded byte of a pixel: green, red, blue, top byte first
    function automatic logic [7:0] slot_byte(input logic [PIX_W-1:0] pix,
                                             input logic [3:0] slot);
        logic [23:0] enc_g;
        logic [23:0] enc_r;
        logic [23:0] enc_b;
        logic [7:0]  res;
        enc_g = encode_byte(pix[15:8]);
        enc_r = encode_byte(pix[23:16]);
        enc_b = encode_byte(pix[7:0]);
        case (slot)
            4'd0:    res = enc_g[23:16];
            4'd1:    res = enc_g[15:8];
            4'd2:    res = enc_g[7:0];
            4'd3:    res = enc_r[23:16];
            4'd4:    res = enc_r[15:8];
            4'd5:    res = enc_r[7:0];
            4'd6:    res = enc_b[23:16];
            4'd7:    res = enc_b[15:8];
            4'd8:    res = enc_b[7:0];
            default: res = '0;
        endcase
        return res;
    endfunction

    // bit 4i+k of the word is bit i of lane k
    function automatic logic [31:0] interleave(input logic [7:0] l0, input logic [7:0] l1,
                                               input logic [7:0] l2, input logic [7:0] l3);
        logic [31:0] w;
        for (int i = 0; i < 8; i++)
        begin
            w[4*i + 0] = l0[i];
            w[4*i + 1] = l1[i];
            w[4*i + 2] = l2[i];
            w[4*i + 3] = l3[i];
        end
        return w;
    endfunction

endpackage

// ===== design/qlse_frame_mem.sv =====
module qlse_frame_mem #(
    parameter int DEPTH = 1920,
    parameter int AW    = 11
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [qlse_pkg::PIX_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [qlse_pkg::PIX_W-1:0] rdata
);
    import qlse_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/quad_lane_led_strip_encoder.sv =====
// Quad-lane LED strip encoder. A write item (op 0) stores one RGB pixel into the frame
// store; writes outside the frame are dropped. An emit item (op 1) reads the LED at the
// serpentine cursor from each of the four panels, one pixel a cycle over the frame
// store's single read port, and then streams nine 32-bit quad-lane words, one per cycle
// while word_ready is high, green then red then blue, each data bit sent as 110 or 100.
// The four reads of the next emit overlap the nine words of the current one. An emit's
// pixels pass from the registered read port into the fill buffer and then into the
// output stage. Writes stall only while the read port is busy; an emit also waits
// until the previous emit's pixels have been captured and handed to the output stage. The
// frame store is not cleared at reset: every pixel must be written before an emit that
// reads it. The cursor resets to LED zero and wraps after the last LED of a panel.
module quad_lane_led_strip_encoder #(
    parameter int FRAME_WIDTH  = 80,
    parameter int FRAME_HEIGHT = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  qlse_pkg::cmd_item_t    cmd,
    output logic                   word_valid,
    input  logic                   word_ready,
    output qlse_pkg::word_item_t   word
);
    import qlse_pkg::*;

    localparam int PANEL_W    = FRAME_WIDTH / 2;
    localparam int PANEL_H    = FRAME_HEIGHT / 2;
    localparam int PANEL_LEDS = PANEL_W * PANEL_H;
    localparam int XW         = (PANEL_W > 1) ? $clog2(PANEL_W) : 1;
    localparam int YW         = (PANEL_H > 1) ? $clog2(PANEL_H) : 1;
    localparam int IW         = (PANEL_LEDS > 1) ? $clog2(PANEL_LEDS) : 1;
    localparam int DEPTH      = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW         = $clog2(DEPTH);
    localparam int XAW        = $clog2(FRAME_WIDTH);
    localparam int YAW        = $clog2(FRAME_HEIGHT);

    localparam logic [XW-1:0] X_LAST = XW'(PANEL_W - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(PANEL_H - 1);
    localparam logic [IW-1:0] I_LAST = IW'(PANEL_LEDS - 1);

    // handshake
    logic cmd_fire;
    logic emit_fire;
    logic wr_fire;
    logic word_fire;
    logic fill_busy;
    logic xfer;

    // led cursor
    logic [XW-1:0] cur_x_reg, cur_x_next;
    logic [YW-1:0] cur_y_reg, cur_y_next;
    logic [IW-1:0] cur_i_reg, cur_i_next;

    // context of the emit being read
    logic [XW-1:0] em_px_reg;
    logic [YW-1:0] em_y_reg;
    logic [IW-1:0] em_i_reg;
    logic          em_end_reg;

    // read sequencer and capture
    logic       rd_busy_reg;
    logic [1:0] rd_lane_reg;
    logic       cap_vld_reg;
    logic [1:0] cap_lane_reg;
    logic       fill_full_reg;
    logic [PIX_W-1:0] fill_pix_reg [4];

    // output stage
    logic             out_busy_reg;
    logic [3:0]       slot_reg;
    logic [PIX_W-1:0] out_pix_reg [4];
    logic [IW-1:0]    out_i_reg;
    logic             out_end_reg;

    // memory ports
    logic [1:0]       rd_panel;
    logic [XAW-1:0]   rd_xa;
    logic [YAW-1:0]   rd_ya;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             wr_in_frame;
    logic [PIX_W-1:0] rdata;

    // output payload
    logic [7:0] lane_byte [4];

    // command side: reads own the memory port, a second emit waits for the fill buffer
    assign fill_busy = cap_vld_reg || fill_full_reg;
    assign cmd_ready = !rd_busy_reg && ((cmd.op == OP_WRITE) || !fill_busy);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign emit_fire = cmd_fire && (cmd.op == OP_EMIT);

    assign wr_in_frame = (32'(cmd.col) < 32'(FRAME_WIDTH)) && (32'(cmd.row) < 32'(FRAME_HEIGHT));
    assign wr_fire     = cmd_fire && (cmd.op == OP_WRITE) && wr_in_frame;
    assign wr_addr     = AW'(cmd.col) * AW'(FRAME_HEIGHT) + AW'(cmd.row);

    // cursor advance, column then panel row then wrap
    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        cur_i_next = cur_i_reg;
        if (emit_fire)
        begin
            if (cur_i_reg == I_LAST)
            begin
                cur_x_next = '0;
                cur_y_next = '0;
                cur_i_next = '0;
            end
            else
            begin
                cur_i_next = cur_i_reg + IW'(1);
                if (cur_x_reg == X_LAST)
                begin
                    cur_x_next = '0;
                    cur_y_next = (cur_y_reg == Y_LAST) ? '0 : cur_y_reg + YW'(1);
                end
                else
                begin
                    cur_x_next = cur_x_reg + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            cur_i_reg <= '0;
        end
        else
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            cur_i_reg <= cur_i_next;
        end
    end

    // emit context, odd panel rows run right to left
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            em_px_reg  <= cur_y_reg[0] ? X_LAST - cur_x_reg : cur_x_reg;
            em_y_reg   <= cur_y_reg;
            em_i_reg   <= cur_i_reg;
            em_end_reg <= (cur_i_reg == I_LAST);
        end
    end

    // read sequencer, one lane per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_busy_reg   <= 1'b0;
            rd_lane_reg   <= '0;
            cap_vld_reg   <= 1'b0;
            cap_lane_reg  <= '0;
            fill_full_reg <= 1'b0;
        end
        else
        begin
            if (emit_fire)
            begin
                rd_busy_reg <= 1'b1;
                rd_lane_reg <= '0;
            end
            else if (rd_busy_reg)
            begin
                rd_lane_reg <= rd_lane_reg + 2'd1;
                if (rd_lane_reg == 2'd3)
                begin
                    rd_busy_reg <= 1'b0;
                end
            end
            cap_vld_reg  <= rd_busy_reg;
            cap_lane_reg <= rd_lane_reg;
            if (cap_vld_reg && (cap_lane_reg == 2'd3))
            begin
                fill_full_reg <= 1'b1;
            end
            else if (xfer)
            begin
                fill_full_reg <= 1'b0;
            end
        end
    end

    // frame address of this lane's panel
    always_comb
    begin
        rd_panel = LANE_PANEL[rd_lane_reg];
        rd_xa    = XAW'(em_px_reg) + (rd_panel[0] ? XAW'(PANEL_W) : XAW'(0));
        rd_ya    = YAW'(em_y_reg) + (rd_panel[1] ? YAW'(PANEL_H) : YAW'(0));
        rd_addr  = AW'(rd_xa) * AW'(FRAME_HEIGHT) + AW'(rd_ya);
    end

    qlse_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (wr_fire),
        .waddr (wr_addr),
        .wdata ({cmd.red, cmd.green, cmd.blue}),
        .re    (rd_busy_reg),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // fill buffer collects the four lane pixels
    always_ff @(posedge clk)
    begin
        if (cap_vld_reg)
        begin
            fill_pix_reg[cap_lane_reg] <= rdata;
        end
    end

    // hand the fill buffer over when the output stage frees up
    assign word_fire = word_valid && word_ready;
    assign xfer      = fill_full_reg && (!out_busy_reg || (word_fire && (slot_reg == SLOT_LAST)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_busy_reg <= 1'b0;
            slot_reg     <= '0;
        end
        else
        begin
            if (xfer)
            begin
                out_busy_reg <= 1'b1;
                slot_reg     <= '0;
            end
            else if (word_fire)
            begin
                if (slot_reg == SLOT_LAST)
                begin
                    out_busy_reg <= 1'b0;
                    slot_reg     <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            out_pix_reg <= fill_pix_reg;
            out_i_reg   <= em_i_reg;
            out_end_reg <= em_end_reg;
        end
    end

    // encode and interleave the current slot
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lane_byte[k] = slot_byte(out_pix_reg[k], slot_reg);
        end
    end

    assign word_valid      = out_busy_reg;
    assign word.lane_word  = interleave(lane_byte[0], lane_byte[1], lane_byte[2], lane_byte[3]);
    assign word.byte_slot  = slot_reg;
    assign word.led_number = 9'(out_i_reg);
    assign word.group_last = (slot_reg == SLOT_LAST);
    assign word.frame_last = (slot_reg == SLOT_LAST) && out_end_reg;

endmodule

// ===== design/qlse_checker.sv =====
module qlse_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input qlse_pkg::cmd_item_t  cmd,
    input logic                 word_valid,
    input logic                 word_ready,
    input qlse_pkg::word_item_t word
);
    import qlse_pkg::*;

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_ready |=> word_valid && $stable(word))
        else $error("stalled word changed");

    // group end flags follow the slot
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (word.byte_slot <= SLOT_LAST)
                       && (word.group_last == (word.byte_slot == SLOT_LAST))
                       && (!word.frame_last || word.group_last))
        else $error("bad slot or end flags");

    // words of one group come back to back for the same led
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_ready && (word.byte_slot != SLOT_LAST)
        |=> word_valid && (word.byte_slot == $past(word.byte_slot) + 4'd1)
            && (word.led_number == $past(word.led_number)))
        else $error("group broken up");

    // a group starts at slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_ready && word.group_last && $past(1'b1)
        |=> !word_valid || (word.byte_slot == 4'd0))
        else $error("group did not start at slot zero");

endmodule

bind quad_lane_led_strip_encoder qlse_checker u_qlse_checker (.*);

// ===== tb/tb_quad_lane_led_strip_encoder.sv =====
module tb_quad_lane_led_strip_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import qlse_pkg::*;

    localparam int FRAME_W    = 80;
    localparam int FRAME_H    = 24;
    localparam int PANEL_W    = FRAME_W / 2;
    localparam int PANEL_H    = FRAME_H / 2;
    localparam int PANEL_LEDS = PANEL_W * PANEL_H;
    localparam int CYCLE_LIMIT = 500000;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    cmd_item_t  cmd;
    logic       word_valid;
    logic       word_ready;
    word_item_t word;

    // shadow of the frame and the led cursor
    logic [PIX_W-1:0] frame_pix [FRAME_W*FRAME_H];
    bit               pix_known [FRAME_W*FRAME_H];
    int               next_led;

    word_item_t pending_words [$];
    int fail_count;
    int cycle_count;
    int send_idle;
    int recv_idle;
    int hold_left;

    quad_lane_led_strip_encoder #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // frame position of serpentine led idx in a panel
    function automatic void led_xy(input int panel, input int idx, output int x, output int y);
        x = idx % PANEL_W;
        y = idx / PANEL_W;
        if (y % 2 == 1)
        begin
            x = PANEL_W - 1 - x;
        end
        if (panel % 2 == 1)
        begin
            x = x + PANEL_W;
        end
        if (panel >= 2)
        begin
            y = y + PANEL_H;
        end
    endfunction

    // 3-bit line code of one byte, msb code at the top
    function automatic logic [23:0] line_code(input logic [7:0] v);
        logic [23:0] r;
        r = '0;
        for (int b = 7; b >= 0; b--)
        begin
            r = {r[20:0], (v[b] ? CODE_ONE : CODE_ZERO)};
        end
        return r;
    endfunction

    // update the shadow state for one accepted item and queue its words
    task automatic apply_cmd(input cmd_item_t c);
        logic [71:0] lane_stream [4];
        logic [7:0]  lane_byte;
        logic [PIX_W-1:0] pix;
        word_item_t  w;
        int x;
        int y;
        if (c.op == OP_WRITE)
        begin
            if (c.col < FRAME_W && c.row < FRAME_H)
            begin
                frame_pix[c.col*FRAME_H + c.row] = {c.red, c.green, c.blue};
                pix_known[c.col*FRAME_H + c.row] = 1'b1;
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                led_xy(LANE_PANEL[k], next_led, x, y);
                pix = frame_pix[x*FRAME_H + y];
                lane_stream[k] = {line_code(pix[15:8]), line_code(pix[23:16]),
                                  line_code(pix[7:0])};
            end
            for (int s = 0; s < SLOTS; s++)
            begin
                w = '0;
                for (int k = 0; k < 4; k++)
                begin
                    lane_byte = lane_stream[k][71 - 8*s -: 8];
                    for (int i = 0; i < 8; i++)
                    begin
                        w.lane_word[4*i + k] = lane_byte[i];
                    end
                end
                w.byte_slot  = 4'(s);
                w.led_number = 9'(next_led);
                w.group_last = (s == SLOTS - 1);
                w.frame_last = (s == SLOTS - 1) && (next_led == PANEL_LEDS - 1);
                pending_words.push_back(w);
            end
            next_led = (next_led == PANEL_LEDS - 1) ? 0 : next_led + 1;
        end
    endtask

    // offer one item, with random gaps, and wait for its acceptance
    task automatic send_cmd(input cmd_item_t c);
        while ($urandom_range(0, 99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        apply_cmd(c);
    endtask

    task automatic write_pixel(input int x, input int y, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b);
        cmd_item_t c;
        c.op    = OP_WRITE;
        c.col   = 7'(x);
        c.row   = 5'(y);
        c.red   = r;
        c.green = g;
        c.blue  = b;
        send_cmd(c);
    endtask

    // write any missing pixel of the next led group, then emit it
    task automatic emit_next();
        cmd_item_t c;
        int x;
        int y;
        for (int k = 0; k < 4; k++)
        begin
            led_xy(LANE_PANEL[k], next_led, x, y);
            if (!pix_known[x*FRAME_H + y])
            begin
                write_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        c    = cmd_item_t'({5'($urandom), $urandom});
        c.op = OP_EMIT;
        send_cmd(c);
    endtask

    // stop offering items and wait for every queued word
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // field extremes, corners, out-of-frame writes
    task automatic test_directed();
        // led 0: all ones, all zeros, alternating bits per lane
        write_pixel(0, PANEL_H, 8'hff, 8'hff, 8'hff);
        write_pixel(0, 0, 8'h00, 8'h00, 8'h00);
        write_pixel(PANEL_W, 0, 8'haa, 8'haa, 8'haa);
        write_pixel(PANEL_W, PANEL_H, 8'h55, 8'h55, 8'h55);
        emit_next();
        // led 1: distinct colors per channel
        write_pixel(1, PANEL_H, 8'hff, 8'h00, 8'h80);
        write_pixel(1, 0, 8'h01, 8'hfe, 8'h7f);
        write_pixel(PANEL_W + 1, 0, 8'h00, 8'hff, 8'h01);
        write_pixel(PANEL_W + 1, PANEL_H, 8'h80, 8'h7f, 8'hff);
        emit_next();
        // frame corners
        write_pixel(FRAME_W - 1, 0, 8'h12, 8'h34, 8'h56);
        write_pixel(0, FRAME_H - 1, 8'h9a, 8'hbc, 8'hde);
        write_pixel(FRAME_W - 1, FRAME_H - 1, 8'hff, 8'h0f, 8'hf0);
        // writes outside the frame must change nothing
        write_pixel(127, 31, 8'hff, 8'hff, 8'hff);
        write_pixel(FRAME_W, 0, 8'h00, 8'hff, 8'h00);
        write_pixel(0, FRAME_H, 8'hff, 8'h00, 8'hff);
        write_pixel(FRAME_W - 1, FRAME_H, 8'h5a, 8'ha5, 8'h5a);
        write_pixel(FRAME_W, FRAME_H - 1, 8'ha5, 8'h5a, 8'ha5);
        emit_next();
        wait_drained();
    endtask

    // random mix of emits, refreshes of the next group and noise
    task automatic test_random(input int n_items);
        int pick;
        int x;
        int y;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                emit_next();
            end
            else if (pick < 45)
            begin
                x = $urandom_range(0, 127);
                y = $urandom_range(0, 31);
                if (x < FRAME_W && y < FRAME_H)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        x = $urandom_range(FRAME_W, 127);
                    end
                    else
                    begin
                        y = $urandom_range(FRAME_H, 31);
                    end
                end
                write_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            else if (pick < 65)
            begin
                // overwrite a pixel the next emit will read
                led_xy($urandom_range(0, 3), next_led, x, y);
                write_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            else
            begin
                write_pixel($urandom_range(0, FRAME_W - 1), $urandom_range(0, FRAME_H - 1),
                            8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        wait_drained();
    endtask

    // long receiver hold-off while emits keep coming
    task automatic test_backpressure();
        hold_left = 300;
        for (int n = 0; n < 10; n++)
        begin
            emit_next();
        end
        wait_drained();
    endtask

    // word checking and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_ready <= 1'b0;
        end
        else
        begin
            if (word_valid && word_ready)
            begin
                check_word(word);
            end
            if (hold_left > 0)
            begin
                word_ready <= 1'b0;
                hold_left  <= hold_left - 1;
            end
            else
            begin
                word_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    task automatic check_word(input word_item_t got);
        word_item_t want;
        if (pending_words.size() == 0)
        begin
            $error("word with nothing pending: %h", got);
            fail_count++;
        end
        else
        begin
            want = pending_words.pop_front();
            if (got.lane_word !== want.lane_word)
            begin
                $error("lane_word expected %h actual %h", want.lane_word, got.lane_word);
                fail_count++;
            end
            if (got.byte_slot !== want.byte_slot)
            begin
                $error("byte_slot expected %0d actual %0d", want.byte_slot, got.byte_slot);
                fail_count++;
            end
            if (got.led_number !== want.led_number)
            begin
                $error("led_number expected %0d actual %0d", want.led_number,
                       got.led_number);
                fail_count++;
            end
            if (got.group_last !== want.group_last)
            begin
                $error("group_last expected %b actual %b", want.group_last, got.group_last);
                fail_count++;
            end
            if (got.frame_last !== want.frame_last)
            begin
                $error("frame_last expected %b actual %b", want.frame_last, got.frame_last);
                fail_count++;
            end
        end
    endtask

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        fail_count  = 0;
        cycle_count = 0;
        hold_left   = 0;
        next_led    = 0;
        send_idle   = 30;
        recv_idle   = 63;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(30);
        test_backpressure();

        send_idle = 63;
        recv_idle = 30;
        test_random(30);

        send_idle = 0;
        recv_idle = 0;
        test_random(30);

        // let any trailing activity settle
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
